// ===== hw/rtl/osec_pkg.sv =====
`default_nettype none
package osec_pkg;

    // field widths
    localparam int EB = 56;                 // energy
    localparam int MB = 40;                 // table mass
    localparam int FB = 16;                 // fraction bits of relative values
    localparam int TW = 16;                 // tolerance registers
    localparam int QW = 32;                 // shift magnitude
    localparam int SW = 48;                 // shift sum
    localparam int CW = 32;                 // correction count

    // derived arithmetic widths
    localparam int PW = EB + 1;             // momentum magnitude
    localparam int XW = 2 * PW + 1;         // squared domain
    localparam int RW = (XW + 1) / 2;       // square root result
    localparam int PL = (PW + 1) / 2;       // momentum low half
    localparam int PH = PW - PL;            // momentum high half
    localparam int EL = (EB + 1) / 2;
    localparam int EH = EB - EL;
    localparam int ML = (MB + 1) / 2;
    localparam int MH = MB - ML;
    localparam int NW = EB + QW;            // divider remainder
    localparam int DW = RW + FB;            // scaled difference

    // stream widths
    localparam int IN_W  = ((EB + 3 * PW + MB + 7) / 8) * 8;
    localparam int OUT_W = ((EB + QW + CW + SW + QW + 7) / 8) * 8;
    localparam int OUT_U = 3;

    // configuration port
    localparam int AW = 4;
    localparam logic [1:0] IDX_MASS_TOL   = 2'd0;
    localparam logic [1:0] IDX_ENERGY_TOL = 2'd1;
    localparam logic [1:0] IDX_ERR_MODE   = 2'd2;
    localparam logic [TW-1:0] TOL_RESET   = 16'd655;

    // output flag positions in tuser
    localparam int U_CORR = 0;
    localparam int U_WARN = 1;
    localparam int U_ERR  = 2;

endpackage
`default_nettype wire

// ===== hw/rtl/on_shell_energy_correction.sv =====
`default_nettype none
// channel   | dir | tdata (low bit up)                                   | tuser
// ----------+-----+------------------------------------------------------+----------------
// s_axis    | in  | energy_in 56, mom_x 57, mom_y 57, mom_z 57, mass 40  | applies
// m_axis    | out | energy_out 56, shift_mag 32, fix_count 32,           | corrected, warn,
//           |     | shift_sum 48, shift_max 32                           | error_flag
// apb       | in  | mass_tolerance @0, energy_tolerance @4, err mode @8  | -
//
// one particle per cycle while the output is not stalled; 58 root stages
// (one root bit per stage) and 32 divider stages (one quotient bit each)
// synchronous active-low reset clears valid bits, configuration registers and accumulators
// a stall at the output freezes the whole pipe; the output register holds
// accumulators update in the last stage, in transfer order
module on_shell_energy_correction (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // particle input
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // energy_in, mom_x, mom_y, mom_z, table_mass
    input  wire  [osec_pkg::IN_W-1:0]       s_axis_tdata,
    // applies
    input  wire  [0:0]                      s_axis_tuser,
    // result output
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // energy_out, shift_mag, fix_count, shift_sum, shift_max
    output logic [osec_pkg::OUT_W-1:0]      m_axis_tdata,
    // corrected, warn_large, error_flag
    output logic [osec_pkg::OUT_U-1:0]      m_axis_tuser,
    // configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [osec_pkg::AW-1:0]         paddr,
    input  wire  [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int EB = osec_pkg::EB;
    localparam int MB = osec_pkg::MB;
    localparam int FB = osec_pkg::FB;
    localparam int TW = osec_pkg::TW;
    localparam int QW = osec_pkg::QW;
    localparam int SW = osec_pkg::SW;
    localparam int CW = osec_pkg::CW;
    localparam int PW = osec_pkg::PW;
    localparam int XW = osec_pkg::XW;
    localparam int RW = osec_pkg::RW;
    localparam int PL = osec_pkg::PL;
    localparam int PH = osec_pkg::PH;
    localparam int EL = osec_pkg::EL;
    localparam int EH = osec_pkg::EH;
    localparam int ML = osec_pkg::ML;
    localparam int MH = osec_pkg::MH;
    localparam int NW = osec_pkg::NW;
    localparam int DW = osec_pkg::DW;
    localparam int OW = osec_pkg::OUT_W;

    // stage types
    typedef struct packed {
        logic          vld;
        logic [EB-1:0] e;
        logic [2:0][PW-1:0] p;
        logic [MB-1:0] m;
        logic          app;
    } t_s1;

    typedef struct packed {
        logic          vld;
        logic [EB-1:0] e;
        logic [2:0][2*PH-1:0]  phh;
        logic [2:0][PH+PL-1:0] phl;
        logic [2:0][2*PL-1:0]  pll;
        logic [2*EH-1:0]   ehh;
        logic [EH+EL-1:0]  ehl;
        logic [2*EL-1:0]   ell;
        logic [2*MH-1:0]   mhh;
        logic [MH+ML-1:0]  mhl;
        logic [2*ML-1:0]   mll;
        logic [MB-1:0] m;
        logic [MB+TW-1:0] rhs;
        logic          app;
    } t_s3;

    typedef struct packed {
        logic          vld;
        logic [EB-1:0] e;
        logic [2:0][XW-1:0] sq;
        logic [XW-1:0] e2;
        logic [XW-1:0] m2;
        logic [MB-1:0] m;
        logic [MB+TW-1:0] rhs;
        logic          app;
    } t_s4;

    typedef struct packed {
        logic          vld;
        logic [EB-1:0] e;
        logic [XW-1:0] p2;
        logic [XW-1:0] e2;
        logic [XW-1:0] m2;
        logic [MB-1:0] m;
        logic [MB+TW-1:0] rhs;
        logic          app;
    } t_s5;

    typedef struct packed {
        logic          vld;
        logic [XW-1:0] kx;      // kinetic mass squared, remainder
        logic [RW-1:0] kr;      // kinetic mass root
        logic [XW-1:0] sx;      // on-shell energy squared, remainder
        logic [RW-1:0] sr;
        logic [EB-1:0] e;
        logic [MB-1:0] m;
        logic [MB+TW-1:0] rhs;
        logic          app;
    } t_sq;

    typedef struct packed {
        logic          vld;
        logic [EB-1:0] e;
        logic [RW-1:0] mdiff;
        logic [RW-1:0] es;
        logic [MB+TW-1:0] rhs;
        logic          app;
    } t_c1;

    typedef struct packed {
        logic          vld;
        logic [NW-1:0] n;
        logic [QW-1:0] q;
        logic [EB-1:0] e;
        logic [EB-1:0] e_out;
        logic          corr;
        logic          sat;
        logic          ezero;
        logic          eszero;
    } t_dv;

    typedef struct packed {
        logic          vld;
        logic [EB-1:0] e_out;
        logic          corr;
        logic [QW-1:0] shift;
    } t_f1;

    // configuration registers
    logic [TW-1:0] r_mass_tol;
    logic [TW-1:0] r_energy_tol;
    logic          r_err_mode;

    // pipeline registers
    t_s1 r_s1;
    t_s1 r_s2;              // same layout, momenta as magnitudes
    t_s3 r_s3;
    t_s4 r_s4;
    t_s5 r_s5;
    t_sq r_sq [0:RW];
    t_c1 r_c1;
    t_dv r_dv [0:QW];
    t_f1 r_f1;

    // output and accumulators
    logic          r_out_vld;
    logic [EB-1:0] r_out_e;
    logic          r_out_corr;
    logic          r_out_warn;
    logic          r_out_err;
    logic [QW-1:0] r_out_shift;
    logic [CW-1:0] r_fix;
    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_max;

    logic en;

    // whole pipe advances when the output register is free or drained
    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_tol   <= osec_pkg::TOL_RESET;
            r_energy_tol <= osec_pkg::TOL_RESET;
            r_err_mode   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                osec_pkg::IDX_MASS_TOL:   r_mass_tol   <= pwdata[TW-1:0];
                osec_pkg::IDX_ENERGY_TOL: r_energy_tol <= pwdata[TW-1:0];
                osec_pkg::IDX_ERR_MODE:   r_err_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            osec_pkg::IDX_MASS_TOL:   prdata = {{(32-TW){1'b0}}, r_mass_tol};
            osec_pkg::IDX_ENERGY_TOL: prdata = {{(32-TW){1'b0}}, r_energy_tol};
            osec_pkg::IDX_ERR_MODE:   prdata = {31'd0, r_err_mode};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- s1: input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (en) begin
            r_s1.vld  <= s_axis_tvalid;
            r_s1.e    <= s_axis_tdata[EB-1:0];
            r_s1.p[0] <= s_axis_tdata[EB+PW-1:EB];
            r_s1.p[1] <= s_axis_tdata[EB+2*PW-1:EB+PW];
            r_s1.p[2] <= s_axis_tdata[EB+3*PW-1:EB+2*PW];
            r_s1.m    <= s_axis_tdata[EB+3*PW+MB-1:EB+3*PW];
            r_s1.app  <= s_axis_tuser[0];
        end
    end

    // ---------------- s2: momentum magnitudes ----------------
    t_s1 n_s2;
    always_comb begin
        n_s2 = r_s1;
        for (int k = 0; k < 3; k++) begin
            if (r_s1.p[k][PW-1]) n_s2.p[k] = ~r_s1.p[k] + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (en) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------- s3: split partial products ----------------
    t_s3 n_s3;
    always_comb begin
        n_s3.vld = r_s2.vld;
        n_s3.e   = r_s2.e;
        n_s3.m   = r_s2.m;
        n_s3.app = r_s2.app;
        for (int k = 0; k < 3; k++) begin
            n_s3.phh[k] = r_s2.p[k][PW-1:PL] * r_s2.p[k][PW-1:PL];
            n_s3.phl[k] = r_s2.p[k][PW-1:PL] * r_s2.p[k][PL-1:0];
            n_s3.pll[k] = r_s2.p[k][PL-1:0] * r_s2.p[k][PL-1:0];
        end
        n_s3.ehh = r_s2.e[EB-1:EL] * r_s2.e[EB-1:EL];
        n_s3.ehl = r_s2.e[EB-1:EL] * r_s2.e[EL-1:0];
        n_s3.ell = r_s2.e[EL-1:0] * r_s2.e[EL-1:0];
        n_s3.mhh = r_s2.m[MB-1:ML] * r_s2.m[MB-1:ML];
        n_s3.mhl = r_s2.m[MB-1:ML] * r_s2.m[ML-1:0];
        n_s3.mll = r_s2.m[ML-1:0] * r_s2.m[ML-1:0];
        // mass tolerance times mass, compared against the scaled difference later
        n_s3.rhs = r_mass_tol * r_s2.m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else if (en) begin
            r_s3 <= n_s3;
        end
    end

    // ---------------- s4: assemble squares ----------------
    t_s4 n_s4;
    always_comb begin
        n_s4.vld = r_s3.vld;
        n_s4.e   = r_s3.e;
        n_s4.m   = r_s3.m;
        n_s4.rhs = r_s3.rhs;
        n_s4.app = r_s3.app;
        for (int k = 0; k < 3; k++) begin
            n_s4.sq[k] = (XW'(r_s3.phh[k]) << (2 * PL)) + (XW'(r_s3.phl[k]) << (PL + 1))
                       + XW'(r_s3.pll[k]);
        end
        n_s4.e2 = (XW'(r_s3.ehh) << (2 * EL)) + (XW'(r_s3.ehl) << (EL + 1)) + XW'(r_s3.ell);
        n_s4.m2 = (XW'(r_s3.mhh) << (2 * ML)) + (XW'(r_s3.mhl) << (ML + 1)) + XW'(r_s3.mll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else if (en) begin
            r_s4 <= n_s4;
        end
    end

    // ---------------- s5: momentum squared ----------------
    t_s5 n_s5;
    always_comb begin
        n_s5.vld = r_s4.vld;
        n_s5.e   = r_s4.e;
        n_s5.m   = r_s4.m;
        n_s5.rhs = r_s4.rhs;
        n_s5.app = r_s4.app;
        n_s5.p2  = r_s4.sq[0] + r_s4.sq[1] + r_s4.sq[2];
        n_s5.e2  = r_s4.e2;
        n_s5.m2  = r_s4.m2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.vld <= 1'b0;
        end else if (en) begin
            r_s5 <= n_s5;
        end
    end

    // ---------------- s6: radicands ----------------
    t_sq n_sq0;
    always_comb begin
        n_sq0.vld = r_s5.vld;
        n_sq0.e   = r_s5.e;
        n_sq0.m   = r_s5.m;
        n_sq0.rhs = r_s5.rhs;
        n_sq0.app = r_s5.app;
        n_sq0.kx  = (r_s5.e2 >= r_s5.p2) ? r_s5.e2 - r_s5.p2 : r_s5.p2 - r_s5.e2;
        n_sq0.kr  = '0;
        n_sq0.sx  = r_s5.p2 + r_s5.m2;
        n_sq0.sr  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0].vld <= 1'b0;
        end else if (en) begin
            r_sq[0] <= n_sq0;
        end
    end

    // ---------------- two square roots, one result bit per stage ----------------
    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int B = RW - 1 - j;
        logic [XW:0] tk;
        logic [XW:0] ts;
        t_sq         n_sq;

        always_comb begin
            n_sq = r_sq[j];
            tk = ({{(XW + 1 - RW){1'b0}}, r_sq[j].kr} << (B + 1)) | ((XW + 1)'(1) << (2 * B));
            ts = ({{(XW + 1 - RW){1'b0}}, r_sq[j].sr} << (B + 1)) | ((XW + 1)'(1) << (2 * B));
            if ({1'b0, r_sq[j].kx} >= tk) begin
                n_sq.kx    = r_sq[j].kx - tk[XW-1:0];
                n_sq.kr[B] = 1'b1;
            end
            if ({1'b0, r_sq[j].sx} >= ts) begin
                n_sq.sx    = r_sq[j].sx - ts[XW-1:0];
                n_sq.sr[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[j+1].vld <= 1'b0;
            end else if (en) begin
                r_sq[j+1] <= n_sq;
            end
        end
    end

    // ---------------- c1: mass difference, rounded on-shell energy ----------------
    t_c1           n_c1;
    logic [RW-1:0] c1_m;
    always_comb begin
        c1_m      = RW'(r_sq[RW].m);
        n_c1.vld  = r_sq[RW].vld;
        n_c1.e    = r_sq[RW].e;
        n_c1.rhs  = r_sq[RW].rhs;
        n_c1.app  = r_sq[RW].app;
        n_c1.mdiff = (r_sq[RW].kr >= c1_m) ? r_sq[RW].kr - c1_m : c1_m - r_sq[RW].kr;
        // round to nearest: bump when the remainder exceeds the floor root
        n_c1.es   = r_sq[RW].sr
                  + RW'({{(XW - RW){1'b0}}, r_sq[RW].sr} < r_sq[RW].sx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.vld <= 1'b0;
        end else if (en) begin
            r_c1 <= n_c1;
        end
    end

    // ---------------- c2: decision, energy shift, divider setup ----------------
    t_dv           n_dv0;
    logic [RW-1:0] c2_e;
    logic [RW-1:0] c2_d;
    logic [DW-1:0] c2_lhs;
    logic [EB-1:0] c2_es_sat;
    always_comb begin
        c2_e   = RW'(r_c1.e);
        c2_d   = (r_c1.es >= c2_e) ? r_c1.es - c2_e : c2_e - r_c1.es;
        c2_lhs = {r_c1.mdiff, {FB{1'b0}}};
        c2_es_sat = (|r_c1.es[RW-1:EB]) ? {EB{1'b1}} : r_c1.es[EB-1:0];
        n_dv0.vld    = r_c1.vld;
        n_dv0.corr   = r_c1.app && (c2_lhs >= DW'(r_c1.rhs));
        n_dv0.e      = r_c1.e;
        n_dv0.e_out  = n_dv0.corr ? c2_es_sat : r_c1.e;
        n_dv0.n      = NW'({c2_d, {FB{1'b0}}});
        n_dv0.q      = '0;
        n_dv0.sat    = NW'({c2_d, {FB{1'b0}}}) >= {r_c1.e, {QW{1'b0}}};
        n_dv0.ezero  = (r_c1.e == '0);
        n_dv0.eszero = (r_c1.es == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int B = QW - 1 - j;
        logic [NW-1:0] td;
        t_dv           n_dv;

        always_comb begin
            n_dv = r_dv[j];
            td   = {{QW{1'b0}}, r_dv[j].e} << B;
            if (r_dv[j].n >= td) begin
                n_dv.n    = r_dv[j].n - td;
                n_dv.q[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1].vld <= 1'b0;
            end else if (en) begin
                r_dv[j+1] <= n_dv;
            end
        end
    end

    // ---------------- f1: shift magnitude ----------------
    t_f1 n_f1;
    always_comb begin
        n_f1.vld   = r_dv[QW].vld;
        n_f1.corr  = r_dv[QW].corr;
        n_f1.e_out = r_dv[QW].e_out;
        if (!r_dv[QW].corr) begin
            n_f1.shift = '0;
        end else if (r_dv[QW].ezero) begin
            // zero input energy: full scale unless the new energy is zero too
            n_f1.shift = r_dv[QW].eszero ? '0 : {QW{1'b1}};
        end else if (r_dv[QW].sat) begin
            n_f1.shift = {QW{1'b1}};
        end else begin
            n_f1.shift = r_dv[QW].q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1.vld <= 1'b0;
        end else if (en) begin
            r_f1 <= n_f1;
        end
    end

    // ---------------- output stage and accumulators ----------------
    logic [CW-1:0] n_fix;
    logic [SW:0]   sum_wide;
    logic [SW-1:0] n_sum;
    logic [QW-1:0] n_max;
    logic          n_warn;
    logic          upd;

    always_comb begin
        upd      = r_f1.vld && r_f1.corr;
        sum_wide = {1'b0, r_sum} + (SW + 1)'(r_f1.shift);
        n_fix    = r_fix;
        n_sum    = r_sum;
        n_max    = r_max;
        if (upd) begin
            if (r_fix != {CW{1'b1}}) n_fix = r_fix + CW'(1);
            n_sum = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
            if (r_f1.shift > r_max) n_max = r_f1.shift;
        end
        n_warn = r_f1.shift > QW'(r_energy_tol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_fix     <= '0;
            r_sum     <= '0;
            r_max     <= '0;
        end else if (en) begin
            r_out_vld   <= r_f1.vld;
            r_out_e     <= r_f1.e_out;
            r_out_corr  <= r_f1.corr;
            r_out_warn  <= n_warn;
            r_out_err   <= n_warn && r_err_mode;
            r_out_shift <= r_f1.shift;
            r_fix       <= n_fix;
            r_sum       <= n_sum;
            r_max       <= n_max;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OW'({r_max, r_sum, r_fix, r_out_shift, r_out_e});

    always_comb begin
        m_axis_tuser                   = '0;
        m_axis_tuser[osec_pkg::U_CORR] = r_out_corr;
        m_axis_tuser[osec_pkg::U_WARN] = r_out_warn;
        m_axis_tuser[osec_pkg::U_ERR]  = r_out_err;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/osec_checker.sv =====
`default_nettype none
module osec_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [osec_pkg::OUT_W-1:0]       m_axis_tdata,
    input wire [osec_pkg::OUT_U-1:0]       m_axis_tuser
);

    logic [osec_pkg::QW-1:0] shift_mag;
    logic [osec_pkg::QW-1:0] shift_max;

    assign shift_mag = m_axis_tdata[osec_pkg::EB +: osec_pkg::QW];
    assign shift_max = m_axis_tdata[osec_pkg::EB + osec_pkg::QW + osec_pkg::CW
                                    + osec_pkg::SW +: osec_pkg::QW];

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // error implies warning implies correction
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tuser[osec_pkg::U_ERR] || m_axis_tuser[osec_pkg::U_WARN])
                       && (!m_axis_tuser[osec_pkg::U_WARN] || m_axis_tuser[osec_pkg::U_CORR]))
        else $error("flag ordering broken");

    // uncorrected items carry no shift
    a_noshift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[osec_pkg::U_CORR] |-> shift_mag == '0)
        else $error("shift on uncorrected item");

    // the running peak covers the current shift
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[osec_pkg::U_CORR] |-> shift_max >= shift_mag)
        else $error("peak below current shift");

endmodule

bind on_shell_energy_correction osec_checker u_osec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== verif/on_shell_energy_correction_tb.sv =====
`timescale 1ns / 1ps
module on_shell_energy_correction_tb;

    localparam int EB    = osec_pkg::EB;
    localparam int MB    = osec_pkg::MB;
    localparam int FB    = osec_pkg::FB;
    localparam int TW    = osec_pkg::TW;
    localparam int QW    = osec_pkg::QW;
    localparam int SW    = osec_pkg::SW;
    localparam int CW    = osec_pkg::CW;
    localparam int PW    = osec_pkg::PW;
    localparam int IN_W  = osec_pkg::IN_W;
    localparam int OUT_W = osec_pkg::OUT_W;
    localparam int OUT_U = osec_pkg::OUT_U;
    localparam int AW    = osec_pkg::AW;
    localparam int U_CORR = osec_pkg::U_CORR;
    localparam int U_WARN = osec_pkg::U_WARN;
    localparam int U_ERR  = osec_pkg::U_ERR;
    localparam logic [1:0] IDX_MASS_TOL   = osec_pkg::IDX_MASS_TOL;
    localparam logic [1:0] IDX_ENERGY_TOL = osec_pkg::IDX_ENERGY_TOL;
    localparam logic [1:0] IDX_ERR_MODE   = osec_pkg::IDX_ERR_MODE;
    localparam logic [TW-1:0] TOL_RESET   = osec_pkg::TOL_RESET;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 258;
    localparam int DRAIN_CYCLES = 220;
    localparam logic [EB-1:0] EMAX = {EB{1'b1}};

    // one particle as driven into the block
    typedef struct {
        logic [EB-1:0] energy;
        logic [PW-1:0] mx, my, mz;       // two's complement
        logic [MB-1:0] mass;
        logic          applies;
        logic          typed;            // expected energy/corrected typed in below
        logic [EB-1:0] t_energy;
        logic          t_corr;
    } t_particle;

    // one expected result
    typedef struct {
        logic [EB-1:0] energy;
        logic          corr, warn, err;
        logic [QW-1:0] shift;
        logic [CW-1:0] count;
        logic [SW-1:0] total;
        logic [QW-1:0] peak;
    } t_outcome;

    logic               i_clk, i_rst_n;
    logic               s_axis_tvalid, s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;    // energy_in, mom_x, mom_y, mom_z, table_mass
    logic [0:0]         s_axis_tuser;    // applies
    logic               m_axis_tvalid, m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;    // energy_out, shift_mag, fix_count, shift_sum, shift_max
    logic [OUT_U-1:0]   m_axis_tuser;    // corrected, warn_large, error_flag
    logic               psel, penable, pwrite, pready;
    logic [AW-1:0]      paddr;
    logic [31:0]        pwdata, prdata;

    on_shell_energy_correction DUT (.*);

    // predictor copy of registers and accumulators
    logic [TW-1:0] mass_tol, energy_tol;
    logic          err_mode;
    logic [CW-1:0] fix_cnt;
    logic [SW-1:0] shift_acc;
    logic [QW-1:0] shift_top;

    t_outcome  pending_results[$];
    t_particle plan[$];
    int        n_errors;
    int        n_checked;
    bit        quiet;                   // no idling on either side

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("on_shell_energy_correction_tb: done, errors");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [127:0] magnitude_of(logic [PW-1:0] v);
        return v[PW-1] ? 128'(-v) & ((128'd1 << PW) - 1) : 128'(v);
    endfunction

    function automatic logic [127:0] isqrt_floor(logic [127:0] x);
        logic [127:0] r, c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [127:0] isqrt_round(logic [127:0] x);
        logic [127:0] s;
        s = isqrt_floor(x);
        // round up when the remainder exceeds s
        if (x - s * s > s)
            s = s + 128'd1;
        return s;
    endfunction

    function automatic logic [127:0] momentum_sq(t_particle p);
        logic [127:0] ax, ay, az;
        ax = magnitude_of(p.mx);
        ay = magnitude_of(p.my);
        az = magnitude_of(p.mz);
        return ax * ax + ay * ay + az * az;
    endfunction

    // works out one result and advances the accumulators
    function automatic t_outcome correct_energy(t_particle p);
        t_outcome     o;
        logic [127:0] p2, e2, k2, mk, diff, es, d, q, m;
        o = '{energy: p.energy, corr: 1'b0, warn: 1'b0, err: 1'b0, shift: '0,
              count: '0, total: '0, peak: '0};
        m = 128'(p.mass);
        if (p.applies) begin
            p2   = momentum_sq(p);
            e2   = 128'(p.energy) * 128'(p.energy);
            k2   = (e2 >= p2) ? e2 - p2 : p2 - e2;
            mk   = isqrt_floor(k2);
            diff = (mk >= m) ? mk - m : m - mk;
            if ((diff << FB) >= 128'(mass_tol) * m) begin
                es = isqrt_round(p2 + m * m);
                d  = (es >= 128'(p.energy)) ? es - 128'(p.energy) : 128'(p.energy) - es;
                o.corr = 1'b1;
                if (p.energy == '0) begin
                    o.shift = (es == '0) ? '0 : '1;
                end else begin
                    q = (d << FB) / 128'(p.energy);
                    o.shift = (q > 128'hFFFF_FFFF) ? '1 : q[QW-1:0];
                end
                if (fix_cnt != '1)
                    fix_cnt = fix_cnt + CW'(1);
                shift_acc = (49'(shift_acc) + 49'(o.shift) > 49'({SW{1'b1}})) ?
                            '1 : shift_acc + SW'(o.shift);
                if (o.shift > shift_top)
                    shift_top = o.shift;
                o.warn   = o.shift > QW'(energy_tol);
                o.err    = o.warn && err_mode;
                o.energy = (es > 128'(EMAX)) ? EMAX : es[EB-1:0];
            end
        end
        o.count = fix_cnt;
        o.total = shift_acc;
        o.peak  = shift_top;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [63:0] rand_upto(int w);
        logic [63:0] v;
        int          n;
        v = {$urandom, $urandom};
        n = $urandom_range(0, w);
        return (n == 0) ? 64'd0 : v & ((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [PW-1:0] signed_mom(logic [63:0] mag);
        logic [PW-1:0] v;
        v = PW'(mag[EB-1:0]);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic t_particle particle(logic [EB-1:0] e, logic [PW-1:0] x,
            logic [PW-1:0] y, logic [PW-1:0] z, logic [MB-1:0] m, logic a,
            logic typed, logic [EB-1:0] te, logic tc);
        return '{energy: e, mx: x, my: y, mz: z, mass: m, applies: a,
                 typed: typed, t_energy: te, t_corr: tc};
    endfunction

    // well-formed particle near its mass shell, with occasional noise
    function automatic t_particle random_particle();
        t_particle    p;
        logic [127:0] es, span;
        int           kind;
        kind = $urandom_range(0, 99);
        p.typed = 1'b0;
        p.t_energy = '0;
        p.t_corr = 1'b0;
        p.applies = ($urandom_range(0, 9) != 0);
        if (kind < 12) begin
            // raw noise over the full field ranges
            p.energy = EB'({$urandom, $urandom});
            p.mx = PW'({$urandom, $urandom});
            p.my = PW'({$urandom, $urandom});
            p.mz = PW'({$urandom, $urandom});
            if (p.mx == (PW'(1) << EB)) p.mx = '0;
            p.mass = MB'({$urandom, $urandom});
        end else begin
            p.mass = MB'(rand_upto(kind < 20 ? MB : 30));
            p.mx = signed_mom(rand_upto(kind < 20 ? EB - 2 : 34));
            p.my = signed_mom(rand_upto(kind < 20 ? EB - 2 : 34));
            p.mz = signed_mom(rand_upto(kind < 20 ? EB - 2 : 34));
            es = isqrt_round(momentum_sq(p) + 128'(p.mass) * 128'(p.mass));
            // perturb by a relative amount from tiny to large
            span = es >> $urandom_range(0, 24);
            span = (span == '0) ? 128'(rand_upto(4)) : span;
            case ($urandom_range(0, 3))
                0: es = es;
                1: es = es + 128'($urandom) % (span + 128'd1);
                2: es = (es > span) ? es - 128'($urandom) % (span + 128'd1) : 128'd0;
                default: es = es + span;
            endcase
            p.energy = (es > 128'(EMAX)) ? EMAX : es[EB-1:0];
        end
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ---------------- bus tasks ----------------

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            IDX_MASS_TOL:   mass_tol   = value[TW-1:0];
            IDX_ENERGY_TOL: energy_tol = value[TW-1:0];
            IDX_ERR_MODE:   err_mode   = value[0];
            default: ;
        endcase
        // the bus goes idle between writes
        @(posedge i_clk);
    endtask

    task automatic set_tolerances(logic [TW-1:0] mt, logic [TW-1:0] et, logic em);
        reg_write(IDX_MASS_TOL, 32'(mt));
        reg_write(IDX_ENERGY_TOL, 32'(et));
        reg_write(IDX_ERR_MODE, 32'(em));
    endtask

    // drive one particle and record its expected result on acceptance
    task automatic send_particle(t_particle p);
        logic [IN_W-1:0] d;
        t_outcome        o;
        int              g;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        d = '0;
        d[EB-1:0]                 = p.energy;
        d[EB +: PW]               = p.mx;
        d[EB + PW +: PW]          = p.my;
        d[EB + 2 * PW +: PW]      = p.mz;
        d[EB + 3 * PW +: MB]      = p.mass;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= p.applies;
        do @(posedge i_clk); while (!s_axis_tready);
        o = correct_energy(p);
        if (p.typed) begin
            o.energy = p.t_energy;
            o.corr   = p.t_corr;
        end
        pending_results.push_back(o);
    endtask

    // sender holds off until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- result checking ----------------

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s at result %0d: got %0h want %0h", what, n_checked, got, want);
        n_errors++;
    endtask

    int stall_left;
    always @(posedge i_clk) begin
        t_outcome o;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected transfer", m_axis_tdata[63:0], 64'd0);
            end else begin
                o = pending_results.pop_front();
                if (m_axis_tdata[EB-1:0] != o.energy)
                    report("energy_out", 64'(m_axis_tdata[EB-1:0]), 64'(o.energy));
                if (m_axis_tuser[U_CORR] != o.corr)
                    report("corrected", 64'(m_axis_tuser[U_CORR]), 64'(o.corr));
                if (m_axis_tuser[U_WARN] != o.warn)
                    report("warn_large", 64'(m_axis_tuser[U_WARN]), 64'(o.warn));
                if (m_axis_tuser[U_ERR] != o.err)
                    report("error_flag", 64'(m_axis_tuser[U_ERR]), 64'(o.err));
                if (m_axis_tdata[EB +: QW] != o.shift)
                    report("shift_mag", 64'(m_axis_tdata[EB +: QW]), 64'(o.shift));
                if (m_axis_tdata[EB + QW +: CW] != o.count)
                    report("fix_count", 64'(m_axis_tdata[EB + QW +: CW]), 64'(o.count));
                if (m_axis_tdata[EB + QW + CW +: SW] != o.total)
                    report("shift_sum", 64'(m_axis_tdata[EB + QW + CW +: SW]), 64'(o.total));
                if (m_axis_tdata[EB + QW + CW + SW +: QW] != o.peak)
                    report("shift_max", 64'(m_axis_tdata[EB + QW + CW + SW +: QW]),
                           64'(o.peak));
            end
            n_checked++;
        end
        // receiver stalls: mostly short, now and then long
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30)
                                                       : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        logic [TW-1:0] mt_set[PHASES] = '{16'd655, 16'd0, 16'hFFFF, 16'd0, 16'd40, 16'hFFFF};
        logic [TW-1:0] et_set[PHASES] = '{16'd655, 16'd0, 16'hFFFF, 16'hFFFF, 16'd3000, 16'd0};
        logic          em_set[PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        logic [PW-1:0] pmax, nmax;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        stall_left = 0;
        quiet = 1'b0;
        n_errors = 0;
        n_checked = 0;
        mass_tol = TOL_RESET;
        energy_tol = TOL_RESET;
        err_mode = 1'b0;
        fix_cnt = '0;
        shift_acc = '0;
        shift_top = '0;
        pmax = PW'(EMAX);
        nmax = -pmax;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, reset register values
        // not qualifying: passes through
        plan.push_back(particle('0, '0, '0, '0, '0, 1'b0, 1'b1, '0, 1'b0));
        plan.push_back(particle(EMAX, pmax, nmax, pmax, '1, 1'b0, 1'b1, EMAX, 1'b0));
        // all zero and qualifying: zero mass forces a correction to zero
        plan.push_back(particle('0, '0, '0, '0, '0, 1'b1, 1'b1, '0, 1'b1));
        // zero energy with a mass: corrected to the mass, full-scale shift
        plan.push_back(particle('0, '0, '0, '0, 40'd1000, 1'b1, 1'b1, 56'd1000, 1'b1));
        // zero mass on shell still counts as corrected
        plan.push_back(particle(56'd5000, 57'd3000, -57'sd4000, '0, '0, 1'b1, 1'b1,
                                56'd5000, 1'b1));
        // at rest on shell, largest mass: left alone
        plan.push_back(particle(56'(40'hFF_FFFF_FFFF), '0, '0, '0, '1, 1'b1, 1'b1,
                                56'(40'hFF_FFFF_FFFF), 1'b0));
        // energy half the mass: doubled, large shift
        plan.push_back(particle(56'd1000, '0, '0, '0, 40'd2000, 1'b1, 1'b1, 56'd2000, 1'b1));
        // on-shell energy too wide: saturates
        plan.push_back(particle(EMAX, pmax, pmax, pmax, '1, 1'b1, 1'b1, EMAX, 1'b1));
        plan.push_back(particle(EMAX, nmax, nmax, nmax, '0, 1'b1, 1'b1, EMAX, 1'b1));
        // predictor-checked rows
        plan.push_back(particle(EMAX, '0, '0, '0, '1, 1'b1, 1'b0, '0, 1'b0));
        plan.push_back(particle(56'd938272, 57'd1, -57'sd1, 57'd1, 40'd938272, 1'b1, 1'b0,
                                '0, 1'b0));
        plan.push_back(particle(56'd940000, '0, '0, '0, 40'd938272, 1'b1, 1'b0, '0, 1'b0));
        plan.push_back(particle(56'd1, pmax, '0, '0, 40'd139570, 1'b1, 1'b0, '0, 1'b0));
        plan.push_back(particle(56'd200000, -57'sd100000, 57'd50000, -57'sd7,
                                40'd139570, 1'b1, 1'b0, '0, 1'b0));
        plan.push_back(particle(56'hAA_AAAA_AAAA_AAAA, 57'h0AA_AAAA_AAAA_AAAA,
                                57'h155_5555_5555_5555, 57'h0, 40'h55_5555_5555, 1'b1, 1'b0,
                                '0, 1'b0));
        plan.push_back(particle(56'h55_5555_5555_5555, 57'h155_5555_5555_5555,
                                57'h0AA_AAAA_AAAA_AAAA, 57'h1, 40'hAA_AAAA_AAAA, 1'b1, 1'b0,
                                '0, 1'b0));
        foreach (plan[k]) send_particle(plan[k]);
        drain();

        // random phases, each under its own tolerance setting
        for (int ph = 0; ph < PHASES; ph++) begin
            set_tolerances(mt_set[ph], et_set[ph], em_set[ph]);
            quiet = (ph == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_particle(random_particle());
            drain();
        end

        if (n_errors == 0)
            $display("on_shell_energy_correction_tb: done, clean");
        else
            $display("on_shell_energy_correction_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/osec_pkg.sv
hw/rtl/on_shell_energy_correction.sv
hw/rtl/osec_checker.sv
verif/on_shell_energy_correction_tb.sv
